// ===== rtl/core/nsr_pkg.sv =====
// ----------------------------------------------------------------------------
// nsr_pkg: shared definitions for the Newton square root block
// Widths, limits, status codes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nsr_pkg;

    // Fixed-point format and iteration limit.
    localparam int FRAC_BITS = 16;
    localparam int MAX_ITER  = 32;

    // Field widths.
    localparam int VALUE_W  = 32;
    localparam int ROOT_W   = 24;
    localparam int STATUS_W = 2;
    localparam int PREC_W   = 17;
    localparam int EST_W    = 32;
    localparam int STEP_W   = 6;

    // Dividend is the non-negative value shifted up by the fraction bits.
    localparam int NUM_W = VALUE_W - 1 + FRAC_BITS;
    localparam int SUM_W = NUM_W + 1;
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [PREC_W-1:0]  PREC_RESET = PREC_W'(7);
    localparam logic [VALUE_W-1:0] ONE_VALUE  = VALUE_W'(1) << FRAC_BITS;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK  = 2'd0,
        ST_NEG = 2'd1,
        ST_CAP = 2'd2
    } t_status;

    // Which result the datapath places in the output register.
    typedef enum logic [1:0] {
        SEL_NEG,
        SEL_TRIV,
        SEL_ITER
    } t_out_sel;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_DIV,
        S_UPDATE,
        S_CHECK,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     div_step;
        logic     update;
        logic     check;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic neg;
        logic trivial;
        logic div_last;
        logic conv;
        logic cap;
    } t_stat;

endpackage

// ===== rtl/core/nsr_dpath.sv =====
// ----------------------------------------------------------------------------
// nsr_dpath: datapath of the Newton square root block
// Holds the input value, the current estimate, the precision register, a
// restoring bit-serial divider and the output payload register.
// ----------------------------------------------------------------------------
module nsr_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nsr_pkg::t_cmd                 i_cmd,
    output nsr_pkg::t_stat                o_stat,
    input  logic signed [nsr_pkg::VALUE_W-1:0] i_value,
    input  logic                          i_cfg_write,
    input  logic [nsr_pkg::PREC_W-1:0]    i_cfg_data,
    output logic [nsr_pkg::ROOT_W-1:0]    o_root,
    output logic [nsr_pkg::STATUS_W-1:0]  o_status
);
    import nsr_pkg::*;

    logic [PREC_W-1:0]   r_prec;
    logic [VALUE_W-1:0]  r_raw;
    logic [EST_W-1:0]    r_x;
    logic [EST_W-1:0]    r_nx;
    logic                r_conv;
    logic [STEP_W-1:0]   r_step_count;
    logic [NUM_W-1:0]    r_div_sh;
    logic [EST_W:0]      r_rem;
    logic [CNT_W-1:0]    r_div_cnt;
    logic [ROOT_W-1:0]   r_root;
    logic [STATUS_W-1:0] r_status;

    logic [EST_W-1:0]    w_divisor;
    logic [EST_W:0]      w_rem_sh;
    logic                w_qbit;
    logic [SUM_W-1:0]    w_sum;
    logic [EST_W-1:0]    w_diff;
    logic [ROOT_W-1:0]   w_sat_root;

    // Precision register, written over the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prec <= PREC_RESET;
        end else if (i_cfg_write) begin
            r_prec <= i_cfg_data;
        end
    end

    // Divider step: shift in the next dividend bit and subtract if it fits.
    always_comb begin
        w_divisor = (r_x == '0) ? EST_W'(1) : r_x;
        w_rem_sh  = {r_rem[EST_W-1:0], r_div_sh[NUM_W-1]};
        w_qbit    = (w_rem_sh >= {1'b0, w_divisor});
    end

    // Next estimate is half the sum of the estimate and the quotient.
    assign w_sum = SUM_W'(r_x) + SUM_W'(r_div_sh);

    // Absolute change between successive estimates.
    assign w_diff = (r_nx >= r_x) ? (r_nx - r_x) : (r_x - r_nx);

    // Roots wider than the output field saturate.
    assign w_sat_root = (|r_nx[EST_W-1:ROOT_W]) ? '1 : r_nx[ROOT_W-1:0];

    // Item capture, divider and estimate registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw        <= i_value;
            r_x          <= i_value;
            r_step_count <= '0;
        end
        if (i_cmd.div_start) begin
            r_div_sh  <= {r_raw[VALUE_W-2:0], FRAC_BITS'(0)};
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= w_qbit ? (w_rem_sh - {1'b0, w_divisor}) : w_rem_sh;
            r_div_sh  <= {r_div_sh[NUM_W-2:0], w_qbit};
            r_div_cnt <= r_div_cnt + CNT_W'(1);
        end
        if (i_cmd.update) begin
            r_nx         <= w_sum[EST_W:1];
            r_step_count <= r_step_count + STEP_W'(1);
        end
        if (i_cmd.check) begin
            r_conv <= o_stat.conv;
            r_x    <= r_nx;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                SEL_NEG: begin
                    r_root   <= '0;
                    r_status <= ST_NEG;
                end
                SEL_TRIV: begin
                    r_root   <= r_raw[ROOT_W-1:0];
                    r_status <= ST_OK;
                end
                SEL_ITER: begin
                    r_root   <= w_sat_root;
                    r_status <= r_conv ? ST_OK : ST_CAP;
                end
                default: begin
                    r_root   <= '0;
                    r_status <= ST_OK;
                end
            endcase
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.neg      = r_raw[VALUE_W-1];
        o_stat.trivial  = (r_raw == '0) || (r_raw == ONE_VALUE);
        o_stat.div_last = (r_div_cnt == CNT_W'(NUM_W - 1));
        o_stat.conv     = (w_diff < EST_W'(r_prec));
        o_stat.cap      = (r_step_count == STEP_W'(MAX_ITER));
    end

    assign o_root   = r_root;
    assign o_status = r_status;

endmodule

// ===== rtl/core/nsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// nsr_ctrl: controller of the Newton square root block
// Sequences item capture, the serial divisions and estimate updates, and
// owns the input stall and the output valid.
// ----------------------------------------------------------------------------
module nsr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  nsr_pkg::t_stat i_stat,
    output nsr_pkg::t_cmd  o_cmd
);
    import nsr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;

    // State register and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CLASSIFY;
            end
            S_CLASSIFY: begin
                if (i_stat.neg || i_stat.trivial) n_state = S_FINISH;
                else                              n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_last) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.conv || i_stat.cap) n_state = S_FINISH;
                else                           n_state = S_DIV;
            end
            S_FINISH: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        o_cmd         = '0;
        o_cmd.out_sel = SEL_ITER;
        n_out_valid   = r_out_valid && i_stall;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = w_accept;
            end
            S_CLASSIFY: begin
                o_cmd.div_start = !(i_stat.neg || i_stat.trivial);
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            S_CHECK: begin
                o_cmd.check     = 1'b1;
                o_cmd.div_start = !(i_stat.conv || i_stat.cap);
            end
            S_FINISH: begin
                o_cmd.out_load = w_out_free;
                if (i_stat.neg)          o_cmd.out_sel = SEL_NEG;
                else if (i_stat.trivial) o_cmd.out_sel = SEL_TRIV;
                else                     o_cmd.out_sel = SEL_ITER;
                if (w_out_free) n_out_valid = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== rtl/core/newton_square_root.sv =====
// ----------------------------------------------------------------------------
// newton_square_root: fixed-point square root by Newton iteration
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// The block takes one signed Q16.16 item at a time and returns its unsigned
// Q8.16 root with a status (0 ok, 1 negative input, 2 iteration cap). Each
// Newton step runs a restoring divider that retires one quotient bit per
// cycle over a 47-bit dividend, then an estimate update and a convergence
// check. An item takes at most 32 steps; negative input, zero and one skip
// the iteration. The input stalls while an item is in work. A finished result
// sits in an output register, so the next item can enter while it waits. The
// precision register takes writes at any time the block is idle.
module newton_square_root (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [nsr_pkg::VALUE_W-1:0]   i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [nsr_pkg::ROOT_W-1:0]           o_root,
    output logic [nsr_pkg::STATUS_W-1:0]         o_status,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [nsr_pkg::PREC_W-1:0]           i_cfg_data
);
    import nsr_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    nsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    nsr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_value     (i_value),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_root      (o_root),
        .o_status    (o_status)
    );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the Newton square root block
// Items enter through a burst driver and results are caught by a monitor that
// compares root and status with a Q16.16 Newton iteration of its own. The run
// walks through several precision settings, the finest and a coarse one among them,
// with directed corner values first and weighted random values after.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nsr_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int TAIL_CYCLES  = 200;
    localparam int REPORT_LIMIT = 10;

    // One expected result, with the value that caused it for reporting.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [ROOT_W-1:0]  root;
        t_status            status;
    } t_root_result;

    logic                       i_clk;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic                       o_stall;
    logic signed [VALUE_W-1:0]  i_value     = '0;
    logic                       o_valid;
    logic                       i_stall     = 1'b0;
    logic [ROOT_W-1:0]          o_root;
    logic [STATUS_W-1:0]        o_status;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [PREC_W-1:0]          i_cfg_data  = '0;

    logic [VALUE_W-1:0] pending_values [$];
    t_root_result       roots_due [$];
    logic [PREC_W-1:0]  precision_now = PREC_RESET;
    bit                 took_value = 1'b0;
    int                 queued_total = 0;
    int                 taken_total = 0;
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 burst_left = 0;
    int                 gap_left = 0;
    int                 stall_mode = 0;
    int                 stall_run = 0;

    newton_square_root dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_root      (o_root),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Heron iteration on the Q16.16 value, truncating divide and halving.
    function automatic t_root_result predict_root(input logic [VALUE_W-1:0] value,
                                                  input logic [PREC_W-1:0]  prec);
        t_root_result res;
        logic [63:0]  dividend;
        logic [63:0]  est;
        logic [63:0]  next_est;
        logic [63:0]  quot;
        logic [63:0]  delta;
        int           steps;
        bit           settled;
        res.value = value;
        if (value[VALUE_W-1]) begin
            res.root   = '0;
            res.status = ST_NEG;
        end else if (value == '0 || value == ONE_VALUE) begin
            res.root   = ROOT_W'(value);
            res.status = ST_OK;
        end else begin
            dividend = 64'(value) << FRAC_BITS;
            est      = 64'(value);
            next_est = est;
            settled  = 1'b0;
            for (steps = 0; steps < MAX_ITER && !settled; steps++) begin
                quot     = dividend / ((est == 64'd0) ? 64'd1 : est);
                next_est = (est + quot) >> 1;
                delta    = (next_est > est) ? next_est - est : est - next_est;
                if (delta < 64'(prec))
                    settled = 1'b1;
                else
                    est = next_est;
            end
            res.root   = (next_est > 64'hFF_FFFF) ? '1 : ROOT_W'(next_est);
            res.status = settled ? ST_OK : ST_CAP;
        end
        return res;
    endfunction

    // Weighted random value: wide patterns, small magnitudes, near squares,
    // and values whose truncated estimates swing between two neighbors.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        logic [63:0]        sq;
        int unsigned        k;
        int unsigned        w;
        v = '0;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: v = $urandom | 32'h8000_0000;
            2: begin
                case ($urandom_range(0, 5))
                    0: v = '0;
                    1: v = ONE_VALUE;
                    2: v = ONE_VALUE - 1;
                    3: v = ONE_VALUE + 1;
                    4: v = 32'd1;
                    default: v = '1;
                endcase
            end
            3, 4, 5: begin
                w = $urandom_range(1, 31);
                v = $urandom & ((32'd1 << w) - 1);
            end
            6: begin
                k  = $urandom_range(1, 32'h00B5_04F3);
                sq = (64'(k) * 64'(k)) >> FRAC_BITS;
                v  = 32'(sq) + 32'($urandom_range(0, 2));
                v[VALUE_W-1] = 1'b0;
            end
            7: begin
                k = $urandom_range(1, 361);
                v = ($urandom_range(0, 1) == 0) ? k * (k * 16384 + 1) : k * (k * 16384 - 1);
            end
            8: v = 32'h7FFF_FFFF - $urandom_range(0, 65535);
            default: v = $urandom_range(1, 255);
        endcase
        return v;
    endfunction

    task automatic queue_value(input logic [VALUE_W-1:0] v);
        pending_values.push_back(v);
        queued_total++;
    endtask

    task automatic queue_random(input int count);
        repeat (count) queue_value(pick_value());
    endtask

    // Block is idle once every queued item went in and every root came back.
    task automatic wait_drained();
        while (taken_total != queued_total || roots_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_precision(input logic [PREC_W-1:0] prec);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= prec;
        do @(posedge i_clk); while (!o_cfg_ready);
        precision_now = prec;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Item driver: bursts of items separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_valid || took_value) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_values.size() != 0) begin
                i_value <= pending_values.pop_front();
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result stall pattern: runs of no stall, light, heavy and solid stall.
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(8, 64);
        end else begin
            stall_run = stall_run - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 2) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= 1'b1;
        endcase
    end

    // Monitor: predict each accepted item and check each delivered root.
    always @(posedge i_clk) begin
        t_root_result want;
        took_value = i_rst_n && i_valid && !o_stall;
        if (took_value) begin
            roots_due.push_back(predict_root(i_value, precision_now));
            taken_total++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (roots_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: root %h status %0d", o_root, o_status);
            end else begin
                want = roots_due.pop_front();
                if (o_root !== want.root || o_status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("value %h: expected root %h status %0d, got root %h status %0d",
                                 want.value, want.root, want.status, o_root, o_status);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corner values at the reset precision.
        @(posedge i_clk);
        queue_value('0);
        queue_value(ONE_VALUE);
        queue_value(32'hFFFF_FFFF);
        queue_value(32'h8000_0000);
        queue_value(32'h7FFF_FFFF);
        queue_value(32'd1);
        queue_value(32'd2);
        queue_value(ONE_VALUE - 1);
        queue_value(ONE_VALUE + 1);
        queue_value(32'h0004_0000);
        queue_value(32'h0002_0000);
        queue_value(32'h0000_0100);
        queue_value(32'h4000_0000);
        queue_value(32'hFFFF_0000);
        queue_value(32'h5555_5555);
        queue_value(32'h2AAA_AAAA);
        wait_drained();

        // Finest precision: estimates that swing by one never settle.
        write_precision(PREC_W'(1));
        @(posedge i_clk);
        queue_value(32'd16385);
        queue_value(32'd65534);
        queue_value(32'd65538);
        queue_value(32'd262140);
        queue_value(32'd361 * (32'd361 * 32'd16384 + 32'd1));
        queue_value(ONE_VALUE);
        queue_random(135);
        wait_drained();

        // Coarse precision.
        write_precision(PREC_W'(65536));
        @(posedge i_clk);
        queue_value(32'h7FFF_FFFF);
        queue_random(140);
        wait_drained();

        // Some precision in between.
        write_precision(PREC_W'($urandom_range(2, 65535)));
        @(posedge i_clk);
        queue_random(140);
        wait_drained();

        // Back to the default precision.
        write_precision(PREC_RESET);
        @(posedge i_clk);
        queue_random(140);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        mismatch_count += roots_due.size();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
